// File: sv/ptp_pkg.sv
// Shared types, character codes and defaults for the polynomial term parser.
package ptp_pkg;

  localparam int COEF_WIDTH_DEF = 32;
  localparam int EXP_WIDTH_DEF  = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Y     = 8'h79;

  typedef enum logic [3:0] {
    CLS_SPACE,
    CLS_STAR,
    CLS_PLUS,
    CLS_MINUS,
    CLS_EQUALS,
    CLS_DIGIT,
    CLS_X,
    CLS_Y,
    CLS_CARET,
    CLS_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIGN,
    PH_COEF,
    PH_BODY,
    PH_CARET,
    PH_EXP
  } phase_t;

  typedef enum logic [1:0] {
    TGT_NONE,
    TGT_X,
    TGT_Y
  } tgt_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_MALFORMED,
    ST_CARET,
    ST_EQUALS,
    ST_EMPTY,
    ST_OVERFLOW
  } status_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] digit;
    logic       fin;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: sv/ptp_front.sv
// Front end: accepts characters and classifies them into queue items.
module ptp_front (
  input  logic                in_valid,
  input  logic [7:0]          in_char_code,
  input  logic                in_is_final,
  output logic                in_stall,
  input  ptp_pkg::q_status_t  q_stat,
  output logic                push,
  output ptp_pkg::qitem_t     push_item
);
  import ptp_pkg::*;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_item.fin   = in_is_final;
    push_item.digit = 4'(in_char_code - CH_ZERO);
    if (in_char_code inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
      push_item.cls = CLS_SPACE;
    end else if (in_char_code == CH_STAR) begin
      push_item.cls = CLS_STAR;
    end else if (in_char_code == CH_PLUS) begin
      push_item.cls = CLS_PLUS;
    end else if (in_char_code == CH_MINUS) begin
      push_item.cls = CLS_MINUS;
    end else if (in_char_code == CH_EQ) begin
      push_item.cls = CLS_EQUALS;
    end else if (in_char_code inside {[CH_ZERO:CH_NINE]}) begin
      push_item.cls = CLS_DIGIT;
    end else if (in_char_code == CH_X) begin
      push_item.cls = CLS_X;
    end else if (in_char_code == CH_Y) begin
      push_item.cls = CLS_Y;
    end else if (in_char_code == CH_CARET) begin
      push_item.cls = CLS_CARET;
    end else begin
      push_item.cls = CLS_OTHER;
    end
  end

endmodule

// File: sv/ptp_queue.sv
// Short queue of classified characters between the front and back ends.
module ptp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ptp_pkg::qitem_t     push_item,
  input  logic                pop,
  output ptp_pkg::qitem_t     pop_item,
  output ptp_pkg::q_status_t  q_stat
);
  import ptp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  qitem_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  assign pop_item     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: sv/ptp_back.sv
// Back end: term parser state machine and the registered result stage.
module ptp_back #(
  parameter int COEF_WIDTH = ptp_pkg::COEF_WIDTH_DEF,
  parameter int EXP_WIDTH  = ptp_pkg::EXP_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ptp_pkg::q_status_t     q_stat,
  input  ptp_pkg::qitem_t        pop_item,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [COEF_WIDTH-1:0] out_coefficient,
  output logic [EXP_WIDTH-1:0]   out_x_power,
  output logic [EXP_WIDTH-1:0]   out_y_power,
  output logic                   out_has_term,
  output logic                   out_end_of_expr,
  output ptp_pkg::status_t       out_status
);
  import ptp_pkg::*;

  localparam int CW = COEF_WIDTH;
  localparam int EW = EXP_WIDTH;
  localparam logic [CW-1:0]   COEF_LIM   = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW+3:0]   COEF_LIM_X = {4'b0000, COEF_LIM};
  localparam logic [EW+3:0]   EXP_MAX_X  = {4'b0000, {EW{1'b1}}};

  typedef struct packed {
    phase_t        phase;
    logic          neg;
    logic [CW-1:0] coef;
    tgt_t          tgt;
    logic [EW-1:0] xa;
    logic [EW-1:0] ya;
    logic [1:0]    vs;
  } term_t;

  typedef struct packed {
    logic          ok;
    status_t       code;
    logic [CW-1:0] coef;
    logic [EW-1:0] x;
    logic [EW-1:0] y;
  } close_t;

  localparam term_t TERM_IDLE = '0;

  term_t         term_r, term_nxt;
  logic          right_r, right_nxt;
  logic          any_r, any_nxt;
  status_t       err_r, err_nxt;

  logic          emit_step;
  logic [CW-1:0] gcoef_step;
  logic [EW-1:0] gx_step, gy_step;

  logic          res_valid;
  logic          res_has;
  logic [CW-1:0] res_coef;
  logic [EW-1:0] res_x, res_y;

  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_coef_r;
  logic [EW-1:0] out_x_r, out_y_r;
  logic          out_has_r, out_end_r;
  status_t       out_status_r;

  logic [CW+3:0] coef_v;
  logic [EW-1:0] exp_sel;
  logic [EW+3:0] exp_v;
  logic          exp_ovf;

  function automatic close_t close_fn(term_t t, logic rs);
    close_t r;
    logic   neg;
    logic   ovf;
    r   = '0;
    neg = t.neg ^ rs;
    ovf = neg ? (t.coef > COEF_LIM) : (t.coef >= COEF_LIM);
    case (t.phase)
      PH_IDLE:  r.ok = 1'b0;
      PH_SIGN:  r.code = ST_MALFORMED;
      PH_CARET: r.code = ST_CARET;
      default: begin
        if (ovf) begin
          r.code = ST_OVERFLOW;
        end else begin
          r.ok   = 1'b1;
          r.coef = neg ? (CW'(0) - t.coef) : t.coef;
          r.x    = t.xa;
          r.y    = t.ya;
        end
      end
    endcase
    return r;
  endfunction

  function automatic term_t count_var(term_t t, cls_t c);
    term_t r;
    r = t;
    if (c == CLS_X && !t.vs[0]) begin
      r.vs[0] = 1'b1;
      r.xa    = EW'(1);
      r.tgt   = TGT_X;
    end else if (c == CLS_Y && !t.vs[1]) begin
      r.vs[1] = 1'b1;
      r.ya    = EW'(1);
      r.tgt   = TGT_Y;
    end else if (c == CLS_CARET && t.tgt != TGT_NONE) begin
      r.phase = PH_CARET;
      if (t.tgt == TGT_X) begin
        r.xa = '0;
      end else begin
        r.ya = '0;
      end
    end else begin
      r.tgt = TGT_NONE;
    end
    return r;
  endfunction

  assign pop = !q_stat.empty && (!out_valid_r || !out_stall);

  // Decimal accumulation by ten as two shifted adds.
  assign coef_v  = ({4'b0000, term_r.coef} << 3) + ({4'b0000, term_r.coef} << 1)
                 + (CW+4)'(pop_item.digit);
  assign exp_sel = (term_r.tgt == TGT_X) ? term_r.xa : term_r.ya;
  assign exp_v   = ({4'b0000, exp_sel} << 3) + ({4'b0000, exp_sel} << 1)
                 + (EW+4)'(pop_item.digit);
  assign exp_ovf = exp_v > EXP_MAX_X;

  // Next state of the parser for the item at the head of the queue.
  always_comb begin : step_logic
    term_t  t;
    close_t c1;
    close_t c2;
    t          = term_r;
    right_nxt  = right_r;
    any_nxt    = any_r;
    err_nxt    = err_r;
    emit_step  = 1'b0;
    gcoef_step = '0;
    gx_step    = '0;
    gy_step    = '0;
    c1         = close_fn(term_r, right_r);
    c2         = '0;
    if (err_r == ST_OK) begin
      if (pop_item.cls != CLS_SPACE) begin
        any_nxt = 1'b1;
      end
      case (pop_item.cls)
        CLS_SPACE, CLS_STAR: begin
          t = term_r;
        end
        CLS_PLUS, CLS_MINUS, CLS_EQUALS: begin
          err_nxt = c1.code;
          if (c1.ok) begin
            emit_step  = 1'b1;
            gcoef_step = c1.coef;
            gx_step    = c1.x;
            gy_step    = c1.y;
          end
          t = TERM_IDLE;
          if (pop_item.cls == CLS_MINUS && err_nxt == ST_OK) begin
            t.phase = PH_SIGN;
            t.neg   = 1'b1;
          end
          if (pop_item.cls == CLS_EQUALS) begin
            if (right_r) begin
              if (err_nxt == ST_OK) err_nxt = ST_EQUALS;
            end else begin
              right_nxt = 1'b1;
            end
          end
        end
        default: begin
          case (term_r.phase)
            PH_IDLE, PH_SIGN: begin
              if (pop_item.cls == CLS_DIGIT) begin
                t.phase = PH_COEF;
                t.coef  = CW'(pop_item.digit);
              end else if (pop_item.cls == CLS_X || pop_item.cls == CLS_Y) begin
                t.phase = PH_BODY;
                t.coef  = CW'(1);
                t       = count_var(t, pop_item.cls);
              end else begin
                err_nxt = ST_MALFORMED;
              end
            end
            PH_COEF: begin
              if (pop_item.cls == CLS_DIGIT) begin
                if (coef_v > COEF_LIM_X) begin
                  err_nxt = ST_OVERFLOW;
                end else begin
                  t.coef = coef_v[CW-1:0];
                end
              end else begin
                t.phase = PH_BODY;
                t       = count_var(t, pop_item.cls);
              end
            end
            PH_CARET, PH_EXP: begin
              if (pop_item.cls == CLS_DIGIT) begin
                t.phase = PH_EXP;
                if (exp_ovf) begin
                  err_nxt = ST_OVERFLOW;
                end else if (term_r.tgt == TGT_X) begin
                  t.xa = exp_v[EW-1:0];
                end else begin
                  t.ya = exp_v[EW-1:0];
                end
              end else if (term_r.phase == PH_CARET) begin
                err_nxt = ST_CARET;
              end else begin
                t.phase = PH_BODY;
                t.tgt   = TGT_NONE;
                t       = count_var(t, pop_item.cls);
              end
            end
            PH_BODY: begin
              t = count_var(term_r, pop_item.cls);
            end
            default: begin
              t = TERM_IDLE;
            end
          endcase
        end
      endcase
      // The final character also closes whatever term is still open.
      if (pop_item.fin && err_nxt == ST_OK) begin
        c2      = close_fn(t, right_nxt);
        err_nxt = c2.code;
        if (c2.ok) begin
          emit_step  = 1'b1;
          gcoef_step = c2.coef;
          gx_step    = c2.x;
          gy_step    = c2.y;
        end
        t = TERM_IDLE;
      end
    end
    if (pop_item.fin && err_nxt == ST_OK && !any_nxt) begin
      err_nxt = ST_EMPTY;
    end
    term_nxt = t;
  end

  // Result formed from the step above.
  always_comb begin
    res_has   = emit_step && (err_nxt == ST_OK);
    res_valid = pop_item.fin || res_has;
    res_coef  = res_has ? gcoef_step : '0;
    res_x     = res_has ? gx_step : '0;
    res_y     = res_has ? gy_step : '0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_valid_r || !out_stall) begin
      out_valid_nxt = pop && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r      <= TERM_IDLE;
      right_r     <= 1'b0;
      any_r       <= 1'b0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        if (pop_item.fin) begin
          term_r  <= TERM_IDLE;
          right_r <= 1'b0;
          any_r   <= 1'b0;
          err_r   <= ST_OK;
        end else begin
          term_r  <= term_nxt;
          right_r <= right_nxt;
          any_r   <= any_nxt;
          err_r   <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_coef_r   <= res_coef;
      out_x_r      <= res_x;
      out_y_r      <= res_y;
      out_has_r    <= res_has;
      out_end_r    <= pop_item.fin;
      out_status_r <= err_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;
  assign out_x_power     = out_x_r;
  assign out_y_power     = out_y_r;
  assign out_has_term    = out_has_r;
  assign out_end_of_expr = out_end_r;
  assign out_status      = out_status_r;

endmodule

// File: sv/polynomial_term_parser.sv
// Top level of the polynomial term parser: front end, queue and back end.
// A character is queued, then its result, if any, is loaded into the output register.
// The parser step and queue take one character per cycle unless out_stall holds a result.
// Reset (rst_n low, synchronous) empties the queue and the result register and clears
// all parser state to the left side with no term open and no error recorded.
module polynomial_term_parser #(
  parameter int COEF_WIDTH = ptp_pkg::COEF_WIDTH_DEF,
  parameter int EXP_WIDTH  = ptp_pkg::EXP_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_char_code,
  input  logic                         in_is_final,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COEF_WIDTH-1:0] out_coefficient,
  output logic [EXP_WIDTH-1:0]         out_x_power,
  output logic [EXP_WIDTH-1:0]         out_y_power,
  output logic                         out_has_term,
  output logic                         out_end_of_expr,
  output ptp_pkg::status_t             out_status
);
  import ptp_pkg::*;

  // The front end classifies each character as it arrives, so the back end only sees
  // a character class, digit value and final flag. It stalls the input transaction only
  // when the queue is full, which never depends on the output side in the same cycle.
  q_status_t q_stat;
  logic      push;
  logic      pop;
  qitem_t    push_item;
  qitem_t    pop_item;

  ptp_front u_front (
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_is_final  (in_is_final),
    .in_stall     (in_stall),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  // The queue decouples the two halves, so a stalled result does not immediately
  // block the input; unstalled, a steady stream flows at one transaction per cycle.
  ptp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // The back end runs the parser step for the head of the queue whenever the result
  // register is empty or being taken, and loads a result when a term closes cleanly
  // or the final character of an expression arrives.
  ptp_back #(
    .COEF_WIDTH (COEF_WIDTH),
    .EXP_WIDTH  (EXP_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop_item        (pop_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_coefficient (out_coefficient),
    .out_x_power     (out_x_power),
    .out_y_power     (out_y_power),
    .out_has_term    (out_has_term),
    .out_end_of_expr (out_end_of_expr),
    .out_status      (out_status)
  );

`ifndef ASSERT_OFF
  // A result that does not end an expression is always a clean term.
  a_mid_result_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_of_expr) |-> (out_status == ST_OK && out_has_term))
    else $error("mid-expression result without a clean term");

  // An error result never carries a term.
  a_error_no_term: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> !out_has_term)
    else $error("error result carries a term");

  // The back end never takes from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue read while empty");

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("queue written while full");
`endif

endmodule
